// File: hw/rtl/u2u8_pkg.sv
// u2u8_pkg: shared types, constants and UTF-8 byte helpers for the transcoder.
// No dependencies; imported by every transcoder module.
package u2u8_pkg;

  localparam int CP_W = 21;

  localparam logic [1:0] PH_MARK0 = 2'd0;
  localparam logic [1:0] PH_MARK1 = 2'd1;
  localparam logic [1:0] PH_CONV  = 2'd2;
  localparam logic [1:0] PH_BAD   = 2'd3;

  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;

  localparam logic [15:0] SURR_HI_LO = 16'hD800;
  localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
  localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] CP_CR = 21'h0000D;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  // one queued job: either an error word or a code point to encode
  typedef struct packed {
    logic            err;
    logic [CP_W-1:0] cp;
  } job_t;

  // number of bytes minus one
  function automatic logic [1:0] job_len_m1(job_t j);
    logic [1:0] r;
    if (j.err || j.cp < 21'h80) r = 2'd0;
    else if (j.cp < 21'h800) r = 2'd1;
    else if (j.cp < 21'h10000) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

  function automatic logic [7:0] job_byte(job_t j, logic [1:0] len_m1, logic [1:0] idx);
    logic [7:0] r;
    logic [1:0] sh;
    sh = len_m1 - idx;
    r = 8'h00;
    if (j.err) begin
      r = 8'h00;
    end else if (idx == 2'd0) begin
      unique case (len_m1)
        2'd0: r = j.cp[7:0];
        2'd1: r = LEAD2 | {3'b000, j.cp[10:6]};
        2'd2: r = LEAD3 | {4'b0000, j.cp[15:12]};
        2'd3: r = LEAD4 | {5'b00000, j.cp[20:18]};
        default: r = 8'h00;
      endcase
    end else begin
      unique case (sh)
        2'd0: r = CONT | {2'b00, j.cp[5:0]};
        2'd1: r = CONT | {2'b00, j.cp[11:6]};
        2'd2: r = CONT | {2'b00, j.cp[17:12]};
        default: r = CONT;
      endcase
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/u2u8_front.sv
// u2u8_front: order-mark check, byte pairing and surrogate joining.
// Uses u2u8_pkg; pushes one job per word that yields output.
module u2u8_front
  import u2u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output logic       push,
  output job_t       push_job
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] mark_r, mark_nxt;
  logic       big_r, big_nxt;
  logic       half_v_r, half_v_nxt;
  logic [7:0] half_b_r, half_b_nxt;
  logic       hs_v_r, hs_v_nxt;
  logic [9:0] hs_r, hs_nxt;
  logic [15:0] unit;
  logic [CP_W-1:0] supp_cp;

  assign unit = big_r ? {half_b_r, data_byte} : {data_byte, half_b_r};
  assign supp_cp = SUPP_BASE + {1'b0, hs_r, unit[9:0]};

  always_comb begin
    phase_nxt  = phase_r;
    mark_nxt   = mark_r;
    big_nxt    = big_r;
    half_v_nxt = half_v_r;
    half_b_nxt = half_b_r;
    hs_v_nxt   = hs_v_r;
    hs_nxt     = hs_r;
    push       = 1'b0;
    push_job   = '0;
    if (acc) begin
      if (end_of_stream) begin
        if (phase_r == PH_MARK1) begin
          push = 1'b1;
          push_job.err = 1'b1;
        end else if (phase_r == PH_CONV && hs_v_r) begin
          push = 1'b1;
          push_job.cp = {5'd0, SURR_HI_TAG, hs_r};
        end
        phase_nxt  = PH_MARK0;
        half_v_nxt = 1'b0;
        half_b_nxt = 8'h00;
        hs_v_nxt   = 1'b0;
        hs_nxt     = 10'd0;
      end else begin
        unique case (phase_r)
          PH_MARK0: begin
            mark_nxt  = data_byte;
            phase_nxt = PH_MARK1;
          end
          PH_MARK1: begin
            if (mark_r == BOM_FF && data_byte == BOM_FE) begin
              big_nxt   = 1'b0;
              phase_nxt = PH_CONV;
            end else if (mark_r == BOM_FE && data_byte == BOM_FF) begin
              big_nxt   = 1'b1;
              phase_nxt = PH_CONV;
            end else begin
              phase_nxt = PH_BAD;
              push = 1'b1;
              push_job.err = 1'b1;
            end
          end
          PH_CONV: begin
            if (!half_v_r) begin
              half_b_nxt = data_byte;
              half_v_nxt = 1'b1;
            end else begin
              half_v_nxt = 1'b0;
              if (hs_v_r) begin
                hs_v_nxt = 1'b0;
                hs_nxt   = 10'd0;
                push = 1'b1;
                push_job.cp = supp_cp;
              end else if (unit >= SURR_HI_LO && unit <= SURR_HI_HI) begin
                hs_nxt   = unit[9:0];
                hs_v_nxt = 1'b1;
              end else begin
                push_job.cp = {5'd0, unit};
                push = (push_job.cp != '0) && (push_job.cp != CP_CR);
              end
            end
          end
          PH_BAD: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MARK0;
      mark_r   <= 8'h00;
      big_r    <= 1'b0;
      half_v_r <= 1'b0;
      half_b_r <= 8'h00;
      hs_v_r   <= 1'b0;
      hs_r     <= 10'd0;
    end else begin
      phase_r  <= phase_nxt;
      mark_r   <= mark_nxt;
      big_r    <= big_nxt;
      half_v_r <= half_v_nxt;
      half_b_r <= half_b_nxt;
      hs_v_r   <= hs_v_nxt;
      hs_r     <= hs_nxt;
    end
  end

endmodule

// File: hw/rtl/u2u8_queue.sv
// u2u8_queue: small job FIFO between front and back ends.
// Uses u2u8_pkg for job_t.
module u2u8_queue
  import u2u8_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == FULL_CNT);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/u2u8_back.sv
// u2u8_back: serialises each job into UTF-8 bytes through an output register.
// Uses u2u8_pkg for job_t and byte helpers.
module u2u8_back
  import u2u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_bom_error
);

  job_t       job_r;
  logic [1:0] len_r, idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       oval_r, oval_nxt;
  logic [7:0] obyte_r;
  logic       olast_r, oerr_r;
  logic       load, emit, last;

  assign load = !oval_r || !out_stall;
  assign emit = busy_r && load;
  assign last = (idx_r == len_r);
  assign pop  = !empty && (!busy_r || (emit && last));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    oval_nxt = oval_r;
    if (emit) begin
      oval_nxt = 1'b1;
      if (last) busy_nxt = 1'b0;
      else idx_nxt = idx_r + 1'b1;
    end else if (!out_stall) begin
      oval_nxt = 1'b0;
    end
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head;
      len_r <= job_len_m1(head);
    end
    if (emit) begin
      obyte_r <= job_byte(job_r, len_r, idx_r);
      olast_r <= last;
      oerr_r  <= job_r.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      oval_r <= oval_nxt;
    end
  end

  assign out_valid       = oval_r;
  assign out_byte        = obyte_r;
  assign out_last_of_run = olast_r;
  assign out_bom_error   = oerr_r;

endmodule

// File: hw/rtl/utf16_to_utf8_transcoder_unit.sv
// utf16_to_utf8_transcoder_unit: top level of the UTF-16 to UTF-8 transcoder.
// Instantiates u2u8_front, u2u8_queue and u2u8_back; uses u2u8_pkg.
//
//  channel | ports                                   | dir | handshake
//  input   | in_data_byte, in_end_of_stream          | in  | in_valid / in_stall
//  result  | out_byte, out_last_of_run, out_bom_error | out | out_valid / out_stall
//
// Input: one byte per cycle while the job queue has room; a word's job is formed
// in the cycle its last byte is taken. Output: one byte per cycle unless out_stall
// holds or no job waits, 1 to 4 per job, set by the single output register.
// rst_n is synchronous; it empties the queue and returns to awaiting an order mark.
// in_stall rises only when the queue is full; out_stall holds the output register.
module utf16_to_utf8_transcoder_unit
  import u2u8_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_bom_error
);

  logic acc, push, pop, empty, full;
  job_t push_job, head;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  u2u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .data_byte     (in_data_byte),
    .end_of_stream (in_end_of_stream),
    .push          (push),
    .push_job      (push_job)
  );

  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  u2u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_bom_error   (out_bom_error)
  );

endmodule
